[rtl/gfd_pkg.sv]
// ----------------------------------------------------------------------------
// gfd_pkg: shared definitions for the gamepad frame decoder
// Field widths, frame positions, button bit numbers, register indexes and
// reset values used by the decoder core, its axis units and its checker.
// ----------------------------------------------------------------------------
package gfd_pkg;

  // Field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned DEADBAND_W = 7;
  localparam int unsigned AXIS_W     = 9;
  localparam int unsigned AXIS_X_W   = 8;

  // Stream and configuration port widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 4;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned CFG_ADDR_W  = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  // Stick rest value; a centered axis is the byte minus this value
  localparam logic [BYTE_W-1:0] CENTER_VALUE = 8'd127;

  // Reset values of the configuration registers and captured bytes
  localparam logic [BYTE_W-1:0]     ANALOG_ID_RST = 8'h73;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RST  = 7'd1;
  localparam logic [BYTE_W-1:0]     MODE_RST      = 8'h00;
  localparam logic [BYTE_W-1:0]     BUTTONS_RST   = 8'hFF;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ANALOG_ID = 1'b0,
    REG_DEADBAND  = 1'b1
  } cfg_reg_t;

  // Byte positions within the poll frame
  localparam logic [POS_W-1:0] POS_MODE    = 4'd1;
  localparam logic [POS_W-1:0] POS_BUTTONS = 4'd4;
  localparam logic [POS_W-1:0] POS_STICK_Z = 4'd5;
  localparam logic [POS_W-1:0] POS_STICK_Y = 4'd7;
  localparam logic [POS_W-1:0] POS_STICK_X = 4'd8;

  // Active-low button bits that drive the mode latches
  localparam int unsigned Y_SET_BIT     = 4;
  localparam int unsigned AVOID_CLR_BIT = 5;
  localparam int unsigned Y_CLR_BIT     = 6;
  localparam int unsigned AVOID_SET_BIT = 7;

endpackage

[rtl/gamepad_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// gamepad_frame_decoder_core: poll frame decoder for an analog gamepad
// Captures mode, button and stick bytes of one poll frame and emits one
// decoded result per frame with centered axes and the two mode latches.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ stream carries one response byte per transfer: in_tdata holds the
//   byte, in_tuser its position in the frame and in_tlast marks the frame's
//   final byte. Each final byte yields one transfer on the out_ stream; other
//   bytes yield none.
//   A final byte passes through the input register, then the decode logic
//   into the result register behind out_tvalid. Throughput is one byte per
//   cycle while in_tready is high, set by the single input register stage;
//   a new byte is taken while a result waits in the output register.
//   If the receiver stalls, the waiting result holds; a further final byte
//   parks in the input register and in_tready drops until the output frees.
//   Non-final bytes keep flowing during a stall.
//   The user writes configuration via cfg_wr_en, cfg_addr and cfg_wdata only
//   while the block is idle; the block does not enforce it. Reset restores the
//   analog ID 0x73, deadband 1, clears both latches, centers captured frame.
// ----------------------------------------------------------------------------
module gamepad_frame_decoder_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [gfd_pkg::IN_TDATA_W-1:0]      in_tdata,   // [7:0] byte_value
  input  logic [gfd_pkg::IN_TUSER_W-1:0]      in_tuser,   // [3:0] byte_pos
  input  logic                                in_tlast,   // frame_end
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] online, [8:1] axis_x, [17:9] axis_y, [26:18] axis_z,
  // [27] y_enabled, [28] avoid_disabled, [31:29] zero
  output logic [gfd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // Configuration port
  input  logic                                cfg_wr_en,
  input  logic [gfd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [gfd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // Configuration registers
  logic [gfd_pkg::BYTE_W-1:0]     analog_id_r;
  logic [gfd_pkg::DEADBAND_W-1:0] deadband_r;

  // Input register stage
  logic                        s1_valid_r, s1_valid_nxt;
  logic [gfd_pkg::BYTE_W-1:0]  s1_byte_r;
  logic [gfd_pkg::POS_W-1:0]   s1_pos_r;
  logic                        s1_last_r;
  logic                        s1_adv;
  logic                        in_xfer;

  // Captured frame bytes and mode latches
  logic [gfd_pkg::BYTE_W-1:0]  mode_r, mode_nxt;
  logic [gfd_pkg::BYTE_W-1:0]  buttons_r, buttons_nxt;
  logic [gfd_pkg::BYTE_W-1:0]  stick_z_r, stick_z_nxt;
  logic [gfd_pkg::BYTE_W-1:0]  stick_y_r, stick_y_nxt;
  logic [gfd_pkg::BYTE_W-1:0]  stick_x_r, stick_x_nxt;
  logic                        y_en_r, y_en_nxt;
  logic                        avoid_dis_r, avoid_dis_nxt;

  // Frame view with the byte in the input register applied
  logic [gfd_pkg::BYTE_W-1:0]  mode_eff, buttons_eff;
  logic [gfd_pkg::BYTE_W-1:0]  stick_z_eff, stick_y_eff, stick_x_eff;
  logic                        online;
  logic                        y_en_upd, avoid_dis_upd;

  // Axis values
  logic signed [gfd_pkg::AXIS_W-1:0]   x_cent, y_cent, z_cent;
  logic [gfd_pkg::AXIS_W-1:0]          x_neg;
  logic [gfd_pkg::AXIS_X_W-1:0]        axis_x;
  logic [gfd_pkg::AXIS_W-1:0]          axis_y, axis_z;

  // Result register
  logic                            out_valid_r, out_valid_nxt;
  logic [gfd_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                            res_load;

  // Handshake: a non-final byte never waits for the output side.
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;
  assign res_load  = s1_adv && s1_last_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Apply the staged byte to the captured frame.
  always_comb begin
    mode_eff    = mode_r;
    buttons_eff = buttons_r;
    stick_z_eff = stick_z_r;
    stick_y_eff = stick_y_r;
    stick_x_eff = stick_x_r;
    case (s1_pos_r)
      gfd_pkg::POS_MODE:    mode_eff    = s1_byte_r;
      gfd_pkg::POS_BUTTONS: buttons_eff = s1_byte_r;
      gfd_pkg::POS_STICK_Z: stick_z_eff = s1_byte_r;
      gfd_pkg::POS_STICK_Y: stick_y_eff = s1_byte_r;
      gfd_pkg::POS_STICK_X: stick_x_eff = s1_byte_r;
      default: ;
    endcase
  end

  assign online = mode_eff == analog_id_r;

  // Latch update: the clear test comes second and wins.
  always_comb begin
    y_en_upd      = y_en_r;
    avoid_dis_upd = avoid_dis_r;
    if (online) begin
      if (!buttons_eff[gfd_pkg::Y_SET_BIT])     y_en_upd      = 1'b1;
      if (!buttons_eff[gfd_pkg::Y_CLR_BIT])     y_en_upd      = 1'b0;
      if (!buttons_eff[gfd_pkg::AVOID_SET_BIT]) avoid_dis_upd = 1'b1;
      if (!buttons_eff[gfd_pkg::AVOID_CLR_BIT]) avoid_dis_upd = 1'b0;
    end
  end

  gfd_axis u_axis_x (
    .stick_byte (stick_x_eff),
    .deadband   (deadband_r),
    .axis_val   (x_cent)
  );

  gfd_axis u_axis_y (
    .stick_byte (stick_y_eff),
    .deadband   (deadband_r),
    .axis_val   (y_cent)
  );

  gfd_axis u_axis_z (
    .stick_byte (stick_z_eff),
    .deadband   (deadband_r),
    .axis_val   (z_cent)
  );

  // X is negated; its range -128..127 fits eight bits.
  assign x_neg  = ~x_cent + 9'd1;
  assign axis_x = online ? x_neg[gfd_pkg::AXIS_X_W-1:0] : '0;
  assign axis_y = (online && y_en_upd) ? y_cent : '0;
  assign axis_z = online ? z_cent : '0;

  // Next state of the captured frame, latches and result register.
  always_comb begin
    mode_nxt      = mode_r;
    buttons_nxt   = buttons_r;
    stick_z_nxt   = stick_z_r;
    stick_y_nxt   = stick_y_r;
    stick_x_nxt   = stick_x_r;
    y_en_nxt      = y_en_r;
    avoid_dis_nxt = avoid_dis_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_load) begin
      // Frame done: report and restart the capture from rest values.
      mode_nxt      = gfd_pkg::MODE_RST;
      buttons_nxt   = gfd_pkg::BUTTONS_RST;
      stick_z_nxt   = gfd_pkg::CENTER_VALUE;
      stick_y_nxt   = gfd_pkg::CENTER_VALUE;
      stick_x_nxt   = gfd_pkg::CENTER_VALUE;
      y_en_nxt      = y_en_upd;
      avoid_dis_nxt = avoid_dis_upd;
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'b000, avoid_dis_upd, y_en_upd, axis_z, axis_y, axis_x, online};
    end else if (s1_adv) begin
      mode_nxt    = mode_eff;
      buttons_nxt = buttons_eff;
      stick_z_nxt = stick_z_eff;
      stick_y_nxt = stick_y_eff;
      stick_x_nxt = stick_x_eff;
    end
  end

  // Control and captured state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      analog_id_r <= gfd_pkg::ANALOG_ID_RST;
      deadband_r  <= gfd_pkg::DEADBAND_RST;
      s1_valid_r  <= 1'b0;
      mode_r      <= gfd_pkg::MODE_RST;
      buttons_r   <= gfd_pkg::BUTTONS_RST;
      stick_z_r   <= gfd_pkg::CENTER_VALUE;
      stick_y_r   <= gfd_pkg::CENTER_VALUE;
      stick_x_r   <= gfd_pkg::CENTER_VALUE;
      y_en_r      <= 1'b0;
      avoid_dis_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (gfd_pkg::cfg_reg_t'(cfg_addr))
          gfd_pkg::REG_ANALOG_ID: analog_id_r <= cfg_wdata;
          gfd_pkg::REG_DEADBAND:  deadband_r  <= cfg_wdata[gfd_pkg::DEADBAND_W-1:0];
          default: ;
        endcase
      end
      s1_valid_r  <= s1_valid_nxt;
      mode_r      <= mode_nxt;
      buttons_r   <= buttons_nxt;
      stick_z_r   <= stick_z_nxt;
      stick_y_r   <= stick_y_nxt;
      stick_x_r   <= stick_x_nxt;
      y_en_r      <= y_en_nxt;
      avoid_dis_r <= avoid_dis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_tdata;
      s1_pos_r  <= in_tuser;
      s1_last_r <= in_tlast;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/gfd_axis.sv]
// ----------------------------------------------------------------------------
// gfd_axis: stick byte centering with deadband
// Subtracts the rest value from a stick byte and forces the result to zero
// when its magnitude is at or below the configured deadband.
// ----------------------------------------------------------------------------
module gfd_axis (
  input  logic [gfd_pkg::BYTE_W-1:0]     stick_byte,
  input  logic [gfd_pkg::DEADBAND_W-1:0] deadband,
  output logic signed [gfd_pkg::AXIS_W-1:0] axis_val
);

  logic [gfd_pkg::AXIS_W-1:0] centered;
  logic [gfd_pkg::AXIS_W-1:0] magnitude;
  logic                       in_band;

  // Centered value spans -127..128, which fits the 9-bit signed result.
  assign centered  = {1'b0, stick_byte} - {1'b0, gfd_pkg::CENTER_VALUE};
  assign magnitude = centered[gfd_pkg::AXIS_W-1] ? (~centered + 9'd1) : centered;
  assign in_band   = magnitude <= {2'b00, deadband};

  assign axis_val = in_band ? '0 : $signed(centered);

endmodule

[rtl/gfd_checker.sv]
// ----------------------------------------------------------------------------
// gfd_checker: port-level assertions for the gamepad frame decoder
// Watches the stream ports of the decoder core over time; bound to the core.
// ----------------------------------------------------------------------------
module gfd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gfd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A final byte transfer shows a result after the input and result registers.
  a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> ##1 out_tvalid)
    else $error("frame end produced no result");

  // An offline frame reports all axes at zero.
  a_offline_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[26:1] == 26'd0)
    else $error("offline result carries nonzero axes");

  // A nonzero Y axis requires the Y enable latch.
  a_y_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17:9] != 9'd0 |-> out_tdata[27])
    else $error("Y axis reported while disabled");

endmodule

bind gamepad_frame_decoder_core gfd_checker u_gfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
